// File: sv/rdd_pkg.sv
// Shared widths, command and register codes, and types of the density deposit block.
package rdd_pkg;

  localparam int unsigned VAL_W      = 56;
  localparam int unsigned CRD_W      = 31;
  localparam int unsigned SIZE_W     = 24;
  localparam int unsigned RATIO_W    = 17;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam int unsigned C2_W   = 35;
  localparam int unsigned DEN_W  = 25;
  localparam int unsigned QMAX_W = 10;
  localparam int unsigned OV_W   = 25;
  localparam int unsigned P_W    = 50;

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEPOSIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_HEIGHT = 2'd3;

  localparam logic [SIZE_W-1:0] BIN_SIZE_RST = 24'd256;

  localparam int unsigned DEF_GRID_COLS = 64;
  localparam int unsigned DEF_GRID_ROWS = 64;

  typedef struct packed {
    logic              neg;
    logic              over;
    logic [QMAX_W-1:0] q;
  } div_res_t;

endpackage

// File: sv/rdd_div.sv
// Iterative floor divider: edge coordinate to bin number, with neg and over flags.
module rdd_div import rdd_pkg::*; #(
  parameter int unsigned LIMIT = DEF_GRID_COLS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [C2_W-1:0] num_i,
  input  logic [DEN_W-1:0]       den_i,
  output logic                   done_o,
  output div_res_t               res_o
);

  localparam int unsigned CNT_W = $clog2(QMAX_W + 2);
  localparam int unsigned REM_W = C2_W - 1;
  localparam int unsigned DSH_W = DEN_W + QMAX_W - 1;
  localparam int unsigned LIM_W = DEN_W + QMAX_W + 1;
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(QMAX_W + 1);

  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [REM_W-1:0]  rem_q;
  logic [DSH_W-1:0]  dsh_q;
  logic [DEN_W-1:0]  den_q;
  logic              neg_q;
  logic              over_q;
  logic [QMAX_W-1:0] q_q;
  logic [LIM_W-1:0]  lim;
  logic              ge;

  always_comb begin
    lim = LIM_W'(den_q) * LIM_W'(LIMIT);
    ge  = DSH_W'(rem_q) >= dsh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1)) && !start_i;
      if (start_i) begin
        cnt_q <= CNT_START;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[REM_W-1:0];
      neg_q <= num_i[C2_W-1];
      den_q <= den_i;
      dsh_q <= DSH_W'(den_i) << (QMAX_W - 1);
      q_q   <= '0;
    end else if (cnt_q == CNT_START) begin
      over_q <= !neg_q && (LIM_W'(rem_q) >= lim);
    end else if (cnt_q != '0) begin
      if (ge) begin
        rem_q <= rem_q - REM_W'(dsh_q);
      end
      q_q   <= {q_q[QMAX_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign res_o  = '{neg: neg_q, over: over_q, q: q_q};

endmodule

// File: sv/rectangle_density_deposit_core.sv
// Top level of the density deposit block: bin memory, command sequencer and deposit datapath.
// After reset the block sweeps the bin memory to zero, one bin per cycle, with busy high.
// A write reports in the cycle after it is accepted; a read registers the bin, then reports
// from ST_RDOUT. A deposit finds its bin range in four iterative dividers and sets up the
// first row in ST_BASE, then passes through ST_OVY for each covered row and through ST_RD,
// ST_MUL, ST_PR and ST_WR for each covered bin, the read-modify-write of the bin memory; an
// empty deposit reports right after the dividers. Each result is shown for one cycle on done_o
// and must be taken then, since the receiver cannot stall the block.
module rectangle_density_deposit_core import rdd_pkg::*; #(
  parameter int unsigned GRID_COLS = DEF_GRID_COLS,
  parameter int unsigned GRID_ROWS = DEF_GRID_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [CRD_W-1:0]      center_x_i,
  input  logic [CRD_W-1:0]      center_y_i,
  input  logic [SIZE_W-1:0]     rect_width_i,
  input  logic [SIZE_W-1:0]     rect_height_i,
  input  logic [RATIO_W-1:0]    charge_ratio_i,
  input  logic [IDX_W-1:0]      bin_index_i,
  input  logic [VAL_W-1:0]      write_value_i,
  output logic                  done_o,
  output logic [VAL_W-1:0]      bin_value_o,
  output logic                  saturated_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned NBINS = GRID_COLS * GRID_ROWS;
  localparam int unsigned AW    = $clog2(NBINS);
  localparam logic [QMAX_W-1:0] XLAST = QMAX_W'(GRID_COLS - 1);
  localparam logic [QMAX_W-1:0] YLAST = QMAX_W'(GRID_ROWS - 1);
  localparam logic [VAL_W-1:0]  VMAX  = '1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RDOUT = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_BASE  = 4'd4;
  localparam logic [3:0] ST_OVY   = 4'd5;
  localparam logic [3:0] ST_RD    = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_PR    = 4'd8;
  localparam logic [3:0] ST_WR    = 4'd9;

  function automatic logic [OV_W-1:0] ovl(input logic signed [C2_W-1:0] lo,
                                          input logic signed [C2_W-1:0] hi,
                                          input logic signed [C2_W-1:0] bl,
                                          input logic signed [C2_W-1:0] size);
    logic signed [C2_W-1:0] top;
    logic signed [C2_W-1:0] bot;
    logic signed [C2_W-1:0] dif;
    top = (hi < bl + size) ? hi : bl + size;
    bot = (lo > bl) ? lo : bl;
    dif = top - bot;
    return (top > bot) ? dif[OV_W-1:0] : '0;
  endfunction

  logic [3:0]          state_q, state_d;
  logic [AW-1:0]       clr_q;
  logic [CRD_W-1:0]    origin_x_q, origin_y_q;
  logic [SIZE_W-1:0]   bin_width_q, bin_height_q;
  logic                done_q, saturated_q, sat_q, rd_ok_q;
  logic [VAL_W-1:0]    bin_value_q;
  logic [VAL_W-1:0]    bins_q [NBINS];
  logic [VAL_W-1:0]    rdata_q;

  logic signed [C2_W-1:0] l2_q, r2_q, b2_q, t2_q;
  logic signed [C2_W-1:0] blx_q, blx0_q, bly_q;
  logic [QMAX_W-1:0]   x0_q, x1_q, bx_q, by_q, y1_q;
  logic [AW-1:0]       rowbase_q, addr_q;
  logic [OV_W-1:0]     ovx_q, ovy_q;
  logic [RATIO_W-1:0]  ratio_q;
  logic [P_W-1:0]      p_q;
  logic [48:0]         hi_q;
  logic [34:0]         lo_q;

  logic                   accept, acc_wr, acc_rd, acc_dep, idx_ok;
  logic [AW-1:0]          idx_addr, cur_addr;
  logic [SIZE_W-1:0]      bw_eff, bh_eff;
  logic [DEN_W-1:0]       bw2u, bh2u;
  logic signed [C2_W-1:0] bw2, bh2, ox2, oy2, l2, r2, b2, t2;
  logic [3:0]             div_done;
  div_res_t               res_lx, res_rx, res_by, res_ty;
  logic [QMAX_W-1:0]      x0, x1, y0, y1;
  logic                   empty;
  logic [P_W-1:0]         amt;
  logic [VAL_W:0]         sum;
  logic                   ovf;
  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [VAL_W-1:0]       wdata;

  always_comb begin
    accept   = start && !busy;
    acc_wr   = accept && (command_i == CMD_WRITE);
    acc_rd   = accept && (command_i == CMD_READ);
    acc_dep  = accept && (command_i == CMD_DEPOSIT);
    idx_ok   = 32'(bin_index_i) < NBINS;
    idx_addr = AW'(bin_index_i);
    cur_addr = rowbase_q + AW'(bx_q);

    bw_eff = (bin_width_q == '0) ? SIZE_W'(1) : bin_width_q;
    bh_eff = (bin_height_q == '0) ? SIZE_W'(1) : bin_height_q;
    bw2u   = {bw_eff, 1'b0};
    bh2u   = {bh_eff, 1'b0};
    bw2    = $signed(C2_W'(bw2u));
    bh2    = $signed(C2_W'(bh2u));
    ox2    = $signed({3'b0, origin_x_q, 1'b0});
    oy2    = $signed({3'b0, origin_y_q, 1'b0});
    l2     = $signed({3'b0, center_x_i, 1'b0}) - $signed(C2_W'(rect_width_i));
    r2     = $signed({3'b0, center_x_i, 1'b0}) + $signed(C2_W'(rect_width_i));
    b2     = $signed({3'b0, center_y_i, 1'b0}) - $signed(C2_W'(rect_height_i));
    t2     = $signed({3'b0, center_y_i, 1'b0}) + $signed(C2_W'(rect_height_i));

    x0    = res_lx.neg ? '0 : res_lx.q;
    x1    = res_rx.over ? XLAST : res_rx.q;
    y0    = res_by.neg ? '0 : res_by.q;
    y1    = res_ty.over ? YLAST : res_ty.q;
    empty = res_lx.over || res_rx.neg || (x0 > x1) ||
            res_by.over || res_ty.neg || (y0 > y1);

    amt = P_W'(hi_q) + P_W'(lo_q[34:18]);
    sum = (VAL_W + 1)'(rdata_q) + (VAL_W + 1)'(amt);
    ovf = sum[VAL_W];

    we    = (state_q == ST_CLEAR) || (acc_wr && idx_ok) || (state_q == ST_WR);
    waddr = (state_q == ST_CLEAR) ? clr_q : ((state_q == ST_WR) ? addr_q : idx_addr);
    wdata = (state_q == ST_CLEAR) ? '0 :
            ((state_q == ST_WR) ? (ovf ? VMAX : sum[VAL_W-1:0]) : write_value_i);
    re    = acc_rd || (state_q == ST_RD);
    raddr = (state_q == ST_RD) ? cur_addr : idx_addr;
  end

  rdd_div #(.LIMIT(GRID_COLS)) u_div_lx (
    .clk_i, .rst_ni, .start_i(acc_dep), .num_i(l2 - ox2), .den_i(bw2u),
    .done_o(div_done[0]), .res_o(res_lx)
  );
  rdd_div #(.LIMIT(GRID_COLS)) u_div_rx (
    .clk_i, .rst_ni, .start_i(acc_dep), .num_i(r2 - ox2), .den_i(bw2u),
    .done_o(div_done[1]), .res_o(res_rx)
  );
  rdd_div #(.LIMIT(GRID_ROWS)) u_div_by (
    .clk_i, .rst_ni, .start_i(acc_dep), .num_i(b2 - oy2), .den_i(bh2u),
    .done_o(div_done[2]), .res_o(res_by)
  );
  rdd_div #(.LIMIT(GRID_ROWS)) u_div_ty (
    .clk_i, .rst_ni, .start_i(acc_dep), .num_i(t2 - oy2), .den_i(bh2u),
    .done_o(div_done[3]), .res_o(res_ty)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AW'(NBINS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (acc_rd) state_d = ST_RDOUT;
        else if (acc_dep) state_d = ST_DIV;
      end
      ST_RDOUT: state_d = ST_IDLE;
      ST_DIV: begin
        if (&div_done) state_d = empty ? ST_IDLE : ST_BASE;
      end
      ST_BASE: state_d = ST_OVY;
      ST_OVY:  state_d = ST_RD;
      ST_RD:   state_d = ST_MUL;
      ST_MUL:  state_d = ST_PR;
      ST_PR:   state_d = ST_WR;
      ST_WR: begin
        if (bx_q != x1_q) state_d = ST_RD;
        else if (by_q != y1_q) state_d = ST_OVY;
        else state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      bin_width_q  <= BIN_SIZE_RST;
      bin_height_q <= BIN_SIZE_RST;
      done_q       <= 1'b0;
      saturated_q  <= 1'b0;
      sat_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= 1'b0;
      saturated_q <= 1'b0;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORIGIN_X:   origin_x_q   <= cfg_wdata_i;
          CFG_ORIGIN_Y:   origin_y_q   <= cfg_wdata_i;
          CFG_BIN_WIDTH:  bin_width_q  <= cfg_wdata_i[SIZE_W-1:0];
          CFG_BIN_HEIGHT: bin_height_q <= cfg_wdata_i[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (accept && (command_i == CMD_WRITE || command_i == CMD_NONE)) begin
        done_q <= 1'b1;
      end
      if (acc_dep) begin
        sat_q <= 1'b0;
      end
      if (state_q == ST_RDOUT) begin
        done_q <= 1'b1;
      end
      if (state_q == ST_DIV && (&div_done) && empty) begin
        done_q <= 1'b1;
      end
      if (state_q == ST_WR) begin
        if (ovf) sat_q <= 1'b1;
        if (bx_q == x1_q && by_q == y1_q) begin
          done_q      <= 1'b1;
          saturated_q <= sat_q || ovf;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      bins_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= bins_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bin_value_q <= '0;
      rd_ok_q     <= idx_ok;
      l2_q        <= l2;
      r2_q        <= r2;
      b2_q        <= b2;
      t2_q        <= t2;
      ratio_q     <= charge_ratio_i;
    end
    case (state_q)
      ST_RDOUT: bin_value_q <= rd_ok_q ? rdata_q : '0;
      ST_DIV: begin
        x0_q <= x0;
        x1_q <= x1;
        bx_q <= x0;
        by_q <= y0;
        y1_q <= y1;
      end
      ST_BASE: begin
        blx0_q    <= ox2 + $signed(C2_W'(x0_q) * C2_W'(bw2u));
        blx_q     <= ox2 + $signed(C2_W'(x0_q) * C2_W'(bw2u));
        bly_q     <= oy2 + $signed(C2_W'(by_q) * C2_W'(bh2u));
        rowbase_q <= AW'(32'(by_q) * GRID_COLS);
      end
      ST_OVY: ovy_q <= ovl(b2_q, t2_q, bly_q, bh2);
      ST_RD: begin
        ovx_q  <= ovl(l2_q, r2_q, blx_q, bw2);
        addr_q <= cur_addr;
      end
      ST_MUL: p_q <= P_W'(ovx_q) * P_W'(ovy_q);
      ST_PR: begin
        hi_q <= 49'(p_q[P_W-1:18]) * 49'(ratio_q);
        lo_q <= 35'(p_q[17:0]) * 35'(ratio_q);
      end
      ST_WR: begin
        if (bx_q != x1_q) begin
          bx_q  <= bx_q + QMAX_W'(1);
          blx_q <= blx_q + bw2;
        end else begin
          bx_q      <= x0_q;
          blx_q     <= blx0_q;
          by_q      <= by_q + QMAX_W'(1);
          bly_q     <= bly_q + bh2;
          rowbase_q <= rowbase_q + AW'(GRID_COLS);
        end
      end
      default: ;
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign bin_value_o = bin_value_q;
  assign saturated_o = saturated_q;

endmodule

// File: sv/rdd_chk.sv
// Port-level checker for the density deposit block and its bind to the top level.
module rdd_chk import rdd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [CMD_W-1:0] command_i,
  input logic             done_o,
  input logic [VAL_W-1:0] bin_value_o,
  input logic             saturated_o
);

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == CMD_WRITE || command_i == CMD_NONE)) |=> done_o)
    else $error("write transfer without a result in the next cycle");

  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CMD_READ) |=> busy ##1 done_o)
    else $error("read transfer without a result two cycles later");

  a_deposit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CMD_DEPOSIT) |=> busy && !done_o)
    else $error("deposit did not hold the block busy");

  a_sat_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saturated_o |-> done_o && bin_value_o == '0)
    else $error("saturation shown outside a deposit result");

endmodule

bind rectangle_density_deposit_core rdd_chk u_rdd_chk (.*);
